FILE: hdl/ppl_pkg.sv
// shared constants, register codes and fixed-point helpers for the phong pixel lighting block
package ppl_pkg;

	localparam int ONE_Q14 = 16384;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	// pipeline geometry
	localparam int SQ_IN_W = 34;
	localparam int LEN_W = SQ_IN_W / 2;
	localparam int QUO_W = 15;
	localparam int POW_W = 17;

	typedef enum logic [2:0] {
		CFG_AMBIENT   = 3'd0,
		CFG_DIFFUSE   = 3'd1,
		CFG_SPECULAR  = 3'd2,
		CFG_SCENE     = 3'd3,
		CFG_LIGHT_POS = 3'd4,
		CFG_EYE_VEC   = 3'd5,
		CFG_SHININESS = 3'd6
	} cfg_reg_t;

	// floor square root, only used on constants at elaboration
	function automatic logic [63:0] isqrt_c(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] x;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		x = v;
		for (int i = 0; i < 32; i++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(-2^-n) in q.30, built by repeated floor square roots from one half
	function automatic logic [30:0] exp_root(input int n);
		logic [63:0] r;
		r = 64'h2000_0000;
		for (int j = 0; j < 16; j++) begin
			if (j < n) begin
				r = isqrt_c(r << 30);
			end
		end
		return r[30:0];
	endfunction

	// signed divide by 2^14, truncating toward zero
	function automatic logic signed [35:0] trunc_q14(input logic signed [35:0] v);
		logic signed [35:0] a;
		a = v + (v[35] ? 36'sd16383 : 36'sd0);
		return a >>> 14;
	endfunction

endpackage

FILE: hdl/ppl_delay.sv
// enabled shift-register delay line for payload alignment
module ppl_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sr_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				sr_q[i] <= sr_q[i-1];
			end
		end
	end

	assign q = sr_q[N-1];

endmodule

FILE: hdl/ppl_isqrt.sv
// pipelined floor square root, one result bit per stage
module ppl_isqrt #(
	parameter int IN_W = 34
) (
	input  logic                clk,
	input  logic                en,
	input  logic [IN_W-1:0]     din,
	output logic [IN_W/2-1:0]   root
);

	localparam int OUT_W = IN_W / 2;
	localparam int RW = OUT_W + 3;

	logic [IN_W-1:0]  val_s [OUT_W];
	logic [IN_W-1:0]  val_n [OUT_W];
	logic [RW-1:0]    rem_s [OUT_W];
	logic [RW-1:0]    rem_n [OUT_W];
	logic [OUT_W-1:0] root_s [OUT_W];
	logic [OUT_W-1:0] root_n [OUT_W];

	for (genvar k = 0; k < OUT_W; k++) begin : g_stage
		logic [IN_W-1:0]  vi;
		logic [RW-1:0]    ri;
		logic [OUT_W-1:0] qi;
		logic [RW-1:0]    cand;
		logic [RW-1:0]    trial;
		logic             ge;
		if (k == 0) begin : g_first
			assign vi = din;
			assign ri = '0;
			assign qi = '0;
		end else begin : g_next
			assign vi = val_s[k-1];
			assign ri = rem_s[k-1];
			assign qi = root_s[k-1];
		end
		// bring down two bits, try root*4+1
		assign cand = {ri[RW-3:0], vi[IN_W-1 -: 2]};
		assign trial = {1'b0, qi, 2'b01};
		assign ge = cand >= trial;
		assign val_n[k] = vi << 2;
		assign rem_n[k] = ge ? cand - trial : cand;
		assign root_n[k] = {qi[OUT_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < OUT_W; k++) begin
				val_s[k] <= val_n[k];
				rem_s[k] <= rem_n[k];
				root_s[k] <= root_n[k];
			end
		end
	end

	assign root = root_s[OUT_W-1];

endmodule

FILE: hdl/ppl_div.sv
// pipelined component normalize: c*2^14/len truncated toward zero
module ppl_div import ppl_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [LEN_W-1:0] c,
	input  logic [LEN_W-1:0]        len,
	output logic signed [15:0]      u
);

	logic             neg;
	logic [LEN_W-1:0] mag;

	logic [LEN_W-1:0] rem_s [QUO_W];
	logic [LEN_W-1:0] rem_n [QUO_W];
	logic [QUO_W-1:0] dl_s [QUO_W];
	logic [QUO_W-1:0] dl_n [QUO_W];
	logic [QUO_W-1:0] q_s [QUO_W];
	logic [QUO_W-1:0] q_n [QUO_W];
	logic [LEN_W-1:0] len_s [QUO_W];
	logic             neg_s [QUO_W];
	logic             zero_s [QUO_W];
	logic signed [15:0] u_s16;

	assign neg = c[LEN_W-1];
	assign mag = neg ? LEN_W'(-c) : LEN_W'(c);

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [LEN_W-1:0] ri;
		logic [QUO_W-1:0] di;
		logic [QUO_W-1:0] qi;
		logic [LEN_W-1:0] li;
		logic [LEN_W:0]   cand;
		logic             ge;
		if (k == 0) begin : g_first
			// quotient fits 15 bits, so the top of the dividend starts as remainder
			assign ri = LEN_W'(mag[15:1]);
			assign di = {mag[0], 14'b0};
			assign qi = '0;
			assign li = len;
		end else begin : g_next
			assign ri = rem_s[k-1];
			assign di = dl_s[k-1];
			assign qi = q_s[k-1];
			assign li = len_s[k-1];
		end
		assign cand = {ri, di[QUO_W-1]};
		assign ge = cand >= {1'b0, li};
		assign rem_n[k] = ge ? LEN_W'(cand - {1'b0, li}) : cand[LEN_W-1:0];
		assign dl_n[k] = di << 1;
		assign q_n[k] = {qi[QUO_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= neg;
			zero_s[0] <= (len == '0);
			len_s[0] <= len;
			for (int k = 0; k < QUO_W; k++) begin
				rem_s[k] <= rem_n[k];
				dl_s[k] <= dl_n[k];
				q_s[k] <= q_n[k];
			end
			for (int k = 1; k < QUO_W; k++) begin
				len_s[k] <= len_s[k-1];
				neg_s[k] <= neg_s[k-1];
				zero_s[k] <= zero_s[k-1];
			end
			// zero-length vector gives a zero unit vector
			if (zero_s[QUO_W-1]) begin
				u_s16 <= '0;
			end else if (neg_s[QUO_W-1]) begin
				u_s16 <= 16'sd0 - signed'(16'(q_s[QUO_W-1]));
			end else begin
				u_s16 <= signed'(16'(q_s[QUO_W-1]));
			end
		end
	end

	assign u = u_s16;

endmodule

FILE: hdl/ppl_pow.sv
// pipelined x^s: log2 by repeated squaring, scale, then exp2 by root products
module ppl_pow import ppl_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [14:0]      x,
	input  logic [15:0]      shin,
	output logic [POW_W-1:0] pw
);

	localparam int NSTEP = 16;

	logic [3:0]  e;
	logic [30:0] mx;

	logic [30:0] m_s1;
	logic [3:0]  ie_s1;

	logic [30:0] m_sq [NSTEP];
	logic [30:0] m_nx [NSTEP];
	logic [15:0] fr_sq [NSTEP];
	logic [15:0] fr_nx [NSTEP];
	logic [3:0]  ie_sq [NSTEP];

	logic [19:0] nl_s18;
	logic [27:0] t_s19;

	logic [30:0] res_ex [NSTEP];
	logic [30:0] res_nx [NSTEP];
	logic [15:0] f_ex [NSTEP];
	logic [4:0]  k_ex [NSTEP];
	logic        z_ex [NSTEP];

	logic [35:0] tprod;
	logic [POW_W-1:0] pw_s36;

	// leading one of x
	always_comb begin
		e = '0;
		for (int b = 1; b < 15; b++) begin
			if (x[b]) begin
				e = 4'(b);
			end
		end
		mx = 31'(x) << (5'd30 - 5'(e));
	end

	for (genvar k = 0; k < NSTEP; k++) begin : g_log
		logic [30:0] mi;
		logic [15:0] fi;
		logic [61:0] mm;
		logic [31:0] sq;
		if (k == 0) begin : g_first
			assign mi = m_s1;
			assign fi = '0;
		end else begin : g_next
			assign mi = m_sq[k-1];
			assign fi = fr_sq[k-1];
		end
		assign mm = {31'b0, mi} * {31'b0, mi};
		assign sq = mm[61:30];
		assign m_nx[k] = sq[31] ? sq[31:1] : sq[30:0];
		assign fr_nx[k] = {fi[14:0], sq[31]};
	end

	assign tprod = 36'(shin) * 36'(nl_s18);

	for (genvar k = 0; k < NSTEP; k++) begin : g_exp
		localparam logic [30:0] RT = exp_root(k + 1);
		logic [30:0] ri;
		logic [15:0] fi;
		logic [61:0] pr;
		if (k == 0) begin : g_first
			assign ri = ONE_Q30;
			assign fi = t_s19[15:0];
		end else begin : g_next
			assign ri = res_ex[k-1];
			assign fi = f_ex[k-1];
		end
		assign pr = {31'b0, ri} * {31'b0, RT};
		assign res_nx[k] = fi[NSTEP-1-k] ? pr[60:30] : ri;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= mx;
			ie_s1 <= 4'd14 - e;
			for (int k = 0; k < NSTEP; k++) begin
				m_sq[k] <= m_nx[k];
				fr_sq[k] <= fr_nx[k];
			end
			ie_sq[0] <= ie_s1;
			for (int k = 1; k < NSTEP; k++) begin
				ie_sq[k] <= ie_sq[k-1];
			end
			nl_s18 <= {ie_sq[NSTEP-1], 16'b0} - {4'b0, fr_sq[NSTEP-1]};
			t_s19 <= tprod[35:8];
			for (int k = 0; k < NSTEP; k++) begin
				res_ex[k] <= res_nx[k];
			end
			f_ex[0] <= t_s19[15:0];
			k_ex[0] <= t_s19[20:16];
			z_ex[0] <= (t_s19[27:16] >= 12'd17);
			for (int k = 1; k < NSTEP; k++) begin
				f_ex[k] <= f_ex[k-1];
				k_ex[k] <= k_ex[k-1];
				z_ex[k] <= z_ex[k-1];
			end
			if (z_ex[NSTEP-1]) begin
				pw_s36 <= '0;
			end else begin
				pw_s36 <= POW_W'(res_ex[NSTEP-1] >> (6'(k_ex[NSTEP-1]) + 6'd14));
			end
		end
	end

	assign pw = pw_s36;

endmodule

FILE: hdl/phong_pixel_lighting.sv
// phong pixel lighting top level: config registers, vector math and color combine
//
// one point light, per-fragment phong shading in fixed point
// input channel: in_valid/in_stall with position (q8.8), normal (q2.14) and base
//   rgba (q0.16); a fragment transfers when in_valid is high and in_stall is low
// output channel: out_valid/out_stall with lit rgba, each channel saturated
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high, unknown indexes are dropped; write only while the pipe is empty
// latency: 81 register stages from input transfer to out_valid
// throughput: one fragment per clock; the stages are the 17-step square root,
//   the 15-step divider, the dot products and the 16+16 step power unit
// the whole pipe moves on one enable; when the result waits under out_stall
//   every stage holds and in_stall rises, nothing is dropped or repeated
// reset clears all valid bits and the registers (shininess to 1.0)
module phong_pixel_lighting import ppl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	input  logic [15:0]        base_r,
	input  logic [15:0]        base_g,
	input  logic [15:0]        base_b,
	input  logic [15:0]        base_a,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        out_r,
	output logic [15:0]        out_g,
	output logic [15:0]        out_b,
	output logic [15:0]        out_a,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	localparam int LAT = 81;
	localparam int D_COMP = 19;
	localparam int D_BASE = 78;
	localparam int D_P = 40;
	localparam int D_SPEC = 36;

	// config registers
	logic [63:0] amb_q;
	logic [63:0] dif_q;
	logic [63:0] spc_q;
	logic [63:0] scn_q;
	logic [47:0] light_q;
	logic [47:0] eye_q;
	logic [15:0] shin_q;

	logic [LAT-1:0] vld_q;
	logic           en;

	logic signed [15:0] pos_v [3];
	logic signed [15:0] nrm_v [3];

	// front end
	logic signed [LEN_W-1:0] lv_s1 [3];
	logic signed [LEN_W-1:0] nv_s1 [3];
	logic signed [LEN_W-1:0] ev_s1 [3];
	logic signed [SQ_IN_W-1:0] le [3];
	logic signed [SQ_IN_W-1:0] ne [3];
	logic signed [SQ_IN_W-1:0] ee [3];
	logic [SQ_IN_W-1:0] sql_s2 [3];
	logic [SQ_IN_W-1:0] sqn_s2 [3];
	logic [SQ_IN_W-1:0] sqe_s2 [3];
	logic [SQ_IN_W-1:0] ssum_s3 [3];
	logic [LEN_W-1:0]   len_v [3];

	logic [9*LEN_W-1:0] comp_in;
	logic [9*LEN_W-1:0] comp_d;
	logic signed [15:0] unit_v [9];

	// dot products and reflection
	logic signed [31:0] pnl_s37 [3];
	logic signed [15:0] n_s37 [3];
	logic signed [15:0] l_s37 [3];
	logic signed [15:0] e_s37 [3];
	logic signed [17:0] d_s38;
	logic [14:0]        p_s38;
	logic signed [15:0] n_s38 [3];
	logic signed [15:0] l_s38 [3];
	logic signed [15:0] e_s38 [3];
	logic signed [35:0] rp_s39 [3];
	logic signed [15:0] l_s39 [3];
	logic signed [15:0] e_s39 [3];
	logic signed [18:0] r_s40 [3];
	logic signed [15:0] e_s40 [3];
	logic signed [35:0] re_s41 [3];
	logic [14:0]        x_s42;
	logic               spec_s42;

	logic signed [35:0] sdot;
	logic signed [35:0] dv;
	logic signed [35:0] sx;
	logic signed [35:0] xv;

	logic [POW_W-1:0] pw;
	logic [63:0]      base_d;
	logic [14:0]      p_d;
	logic             spec_d;

	// color combine
	logic [31:0] ab_s79 [4];
	logic [31:0] db_s79 [4];
	logic [32:0] sp_s79 [4];
	logic [14:0] p_s79;
	logic [31:0] ab_s80 [4];
	logic [32:0] dp_s80 [4];
	logic [32:0] sp_s80 [4];
	logic [15:0] col_s81 [4];
	logic [34:0] csum [4];

	assign cfg_ready = 1'b1;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amb_q <= '0;
			dif_q <= '0;
			spc_q <= '0;
			scn_q <= '0;
			light_q <= '0;
			eye_q <= '0;
			shin_q <= 16'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_AMBIENT:   amb_q <= cfg_data;
				CFG_DIFFUSE:   dif_q <= cfg_data;
				CFG_SPECULAR:  spc_q <= cfg_data;
				CFG_SCENE:     scn_q <= cfg_data;
				CFG_LIGHT_POS: light_q <= cfg_data[47:0];
				CFG_EYE_VEC:   eye_q <= cfg_data[47:0];
				CFG_SHININESS: shin_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// global pipe enable: hold everything while the result waits
	assign out_valid = vld_q[LAT-1];
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	assign pos_v[0] = pos_x;
	assign pos_v[1] = pos_y;
	assign pos_v[2] = pos_z;
	assign nrm_v[0] = norm_x;
	assign nrm_v[1] = norm_y;
	assign nrm_v[2] = norm_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			le[i] = SQ_IN_W'(lv_s1[i]);
			ne[i] = SQ_IN_W'(nv_s1[i]);
			ee[i] = SQ_IN_W'(ev_s1[i]);
		end
	end

	// light, normal and eye vectors, squares, sums of squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				lv_s1[i] <= LEN_W'(signed'(light_q[16*i +: 16])) - LEN_W'(pos_v[i]);
				nv_s1[i] <= LEN_W'(nrm_v[i]);
				ev_s1[i] <= LEN_W'(signed'(eye_q[16*i +: 16]));
				sql_s2[i] <= le[i] * le[i];
				sqn_s2[i] <= ne[i] * ne[i];
				sqe_s2[i] <= ee[i] * ee[i];
			end
			ssum_s3[0] <= sql_s2[0] + sql_s2[1] + sql_s2[2];
			ssum_s3[1] <= sqn_s2[0] + sqn_s2[1] + sqn_s2[2];
			ssum_s3[2] <= sqe_s2[0] + sqe_s2[1] + sqe_s2[2];
		end
	end

	for (genvar v = 0; v < 3; v++) begin : g_len
		ppl_isqrt #(
			.IN_W(SQ_IN_W)
		) u_isqrt (
			.clk  (clk),
			.en   (en),
			.din  (ssum_s3[v]),
			.root (len_v[v])
		);
	end

	// components ride alongside the square roots
	for (genvar i = 0; i < 3; i++) begin : g_pack
		assign comp_in[LEN_W*i +: LEN_W] = lv_s1[i];
		assign comp_in[LEN_W*(3+i) +: LEN_W] = nv_s1[i];
		assign comp_in[LEN_W*(6+i) +: LEN_W] = ev_s1[i];
	end

	ppl_delay #(
		.W(9*LEN_W),
		.N(D_COMP)
	) u_comp_dly (
		.clk (clk),
		.en  (en),
		.d   (comp_in),
		.q   (comp_d)
	);

	// unit vectors: L in 0..2, N in 3..5, E in 6..8
	for (genvar j = 0; j < 9; j++) begin : g_unit
		ppl_div u_div (
			.clk (clk),
			.en  (en),
			.c   (signed'(comp_d[LEN_W*j +: LEN_W])),
			.len (len_v[j/3]),
			.u   (unit_v[j])
		);
	end

	always_comb begin
		sdot = 36'(pnl_s37[0]) + 36'(pnl_s37[1]) + 36'(pnl_s37[2]);
		dv = trunc_q14(sdot);
		sx = re_s41[0] + re_s41[1] + re_s41[2];
		xv = trunc_q14(sx);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// n.l products
			for (int i = 0; i < 3; i++) begin
				pnl_s37[i] <= 32'(unit_v[3+i]) * 32'(unit_v[i]);
				l_s37[i] <= unit_v[i];
				n_s37[i] <= unit_v[3+i];
				e_s37[i] <= unit_v[6+i];
			end
			// diffuse factor, clamped to [0, 1.0]
			d_s38 <= 18'(dv);
			if (dv < 36'sd0) begin
				p_s38 <= '0;
			end else if (dv > 36'(ONE_Q14)) begin
				p_s38 <= 15'(ONE_Q14);
			end else begin
				p_s38 <= 15'(dv);
			end
			n_s38 <= n_s37;
			l_s38 <= l_s37;
			e_s38 <= e_s37;
			// reflection r = 2 d n - l, uses d before the clamp
			for (int i = 0; i < 3; i++) begin
				rp_s39[i] <= (36'(d_s38) * 36'(n_s38[i])) <<< 1;
			end
			l_s39 <= l_s38;
			e_s39 <= e_s38;
			for (int i = 0; i < 3; i++) begin
				r_s40[i] <= 19'(trunc_q14(rp_s39[i])) - 19'(l_s39[i]);
			end
			e_s40 <= e_s39;
			for (int i = 0; i < 3; i++) begin
				re_s41[i] <= 36'(r_s40[i]) * 36'(e_s40[i]);
			end
			// specular dot; non-positive skips specular, power input kept legal
			spec_s42 <= (xv > 36'sd0);
			if (xv <= 36'sd0 || xv > 36'(ONE_Q14)) begin
				x_s42 <= 15'(ONE_Q14);
			end else begin
				x_s42 <= 15'(xv);
			end
		end
	end

	ppl_pow u_pow (
		.clk  (clk),
		.en   (en),
		.x    (x_s42),
		.shin (shin_q),
		.pw   (pw)
	);

	ppl_delay #(
		.W(64),
		.N(D_BASE)
	) u_base_dly (
		.clk (clk),
		.en  (en),
		.d   ({base_a, base_b, base_g, base_r}),
		.q   (base_d)
	);

	ppl_delay #(
		.W(15),
		.N(D_P)
	) u_p_dly (
		.clk (clk),
		.en  (en),
		.d   (p_s38),
		.q   (p_d)
	);

	ppl_delay #(
		.W(1),
		.N(D_SPEC)
	) u_spec_dly (
		.clk (clk),
		.en  (en),
		.d   (spec_s42),
		.q   (spec_d)
	);

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			csum[c] = 35'(ab_s80[c]) + 35'({scn_q[16*c +: 16], 16'b0})
				+ 35'(dp_s80[c]) + 35'(sp_s80[c]);
		end
	end

	// per channel: amb*base + scene + dif*base*p + spc*pow, in q.32
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				ab_s79[c] <= 32'(base_d[16*c +: 16]) * 32'(amb_q[16*c +: 16]);
				db_s79[c] <= 32'(base_d[16*c +: 16]) * 32'(dif_q[16*c +: 16]);
				sp_s79[c] <= spec_d ? 33'(spc_q[16*c +: 16]) * 33'(pw) : '0;
			end
			p_s79 <= p_d;
			for (int c = 0; c < 4; c++) begin
				ab_s80[c] <= ab_s79[c];
				sp_s80[c] <= sp_s79[c];
				dp_s80[c] <= 33'((47'(db_s79[c]) * 47'(p_s79)) >> 14);
			end
			// saturate to q0.16
			for (int c = 0; c < 4; c++) begin
				col_s81[c] <= (csum[c][34:32] != 3'b0) ? 16'hFFFF : csum[c][31:16];
			end
		end
	end

	assign out_r = col_s81[0];
	assign out_g = col_s81[1];
	assign out_b = col_s81[2];
	assign out_a = col_s81[3];

endmodule
